>>> rtl/lpju_pkg.sv
package lpju_pkg;

  // Lattice geometry: the site index spans the whole ring
  localparam int SITES      = 4096;
  localparam int SITE_W     = $clog2(SITES);
  localparam int ROW_W      = SITE_W - 1;
  localparam int BANK_ROWS  = SITES / 2;

  // Shot counter
  localparam int SHOT_INTERVAL = 5000;
  localparam int CNT_W         = 13;

  // Field and register widths
  localparam int FRAC_W       = 16;
  localparam int THR_W        = 17;
  localparam int REG_IDX_W    = 3;
  localparam int FUNC_W       = 2;
  localparam int IN_TDATA_W   = 32;
  localparam int OUT_TDATA_W  = 8;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_INIT   = 2'd0,
    FUNC_UPDATE = 2'd1,
    FUNC_READ   = 2'd2
  } func_t;

  typedef logic signed [1:0] site_t;
  localparam site_t SITE_NEG  = 2'sb11;
  localparam site_t SITE_ZERO = 2'sb00;
  localparam site_t SITE_POS  = 2'sb01;

  typedef enum logic [2:0] {
    RULE_NONE        = 3'd0,
    RULE_LEFT_DRIFT  = 3'd1,
    RULE_RIGHT_DRIFT = 3'd2,
    RULE_ANNIHILATE  = 3'd3,
    RULE_CREATE      = 3'd4
  } rule_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_RATE_LEFT_DRIFT  = 3'd0,
    REG_RATE_RIGHT_DRIFT = 3'd1,
    REG_RATE_ANNIHILATE  = 3'd2,
    REG_RATE_CREATE      = 3'd3,
    REG_INIT_LEFT_LOW    = 3'd4,
    REG_INIT_LEFT_MID    = 3'd5,
    REG_INIT_RIGHT_LOW   = 3'd6,
    REG_INIT_RIGHT_MID   = 3'd7
  } reg_idx_t;

  localparam logic [THR_W-1:0] THR_ZERO = '0;
  localparam logic [THR_W-1:0] THR_FULL = THR_W'(65536);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic commit;
  } lpju_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_stall;
  } lpju_sts_t;

endpackage

>>> rtl/lpju_ctrl.sv
module lpju_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  lpju_pkg::lpju_sts_t sts,
  output lpju_pkg::lpju_cmd_t cmd
);
  import lpju_pkg::*;

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (!sts.out_stall) state_next = ST_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.commit  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_EXEC: begin
        cmd.commit = !sts.out_stall;
      end
    endcase
  end

endmodule

>>> rtl/lpju_datapath.sv
module lpju_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [lpju_pkg::REG_IDX_W-1:0] cfg_addr,
  input  logic [lpju_pkg::THR_W-1:0]    cfg_wdata,
  input  logic [lpju_pkg::FUNC_W-1:0]   in_func,
  input  logic [lpju_pkg::SITE_W-1:0]   in_site,
  input  logic [lpju_pkg::FRAC_W-1:0]   in_frac,
  input  lpju_pkg::lpju_cmd_t           cmd,
  output lpju_pkg::lpju_sts_t           sts,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [lpju_pkg::OUT_TDATA_W-1:0] out_data
);
  import lpju_pkg::*;

  // Configuration registers
  logic [THR_W-1:0] rate_left_drift;
  logic [THR_W-1:0] rate_right_drift;
  logic [THR_W-1:0] rate_annihilate;
  logic [THR_W-1:0] rate_create;
  logic [THR_W-1:0] init_left_low;
  logic [THR_W-1:0] init_left_mid;
  logic [THR_W-1:0] init_right_low;
  logic [THR_W-1:0] init_right_mid;

  // Captured item
  func_t             func;
  logic [SITE_W-1:0] site_a;
  logic [FRAC_W-1:0] frac;

  // Lattice split into even and odd banks: a site and its right neighbour
  // always fall in different banks
  site_t even_bank [BANK_ROWS];
  site_t odd_bank  [BANK_ROWS];
  site_t rd_even;
  site_t rd_odd;

  logic [SITE_W-1:0] in_site_b;
  logic [ROW_W-1:0]  in_row_even;
  logic [ROW_W-1:0]  in_row_odd;
  logic [SITE_W-1:0] site_b;
  logic [ROW_W-1:0]  row_even;
  logic [ROW_W-1:0]  row_odd;

  logic              we_even;
  logic              we_odd;
  site_t             wd_even;
  site_t             wd_odd;

  logic [CNT_W-1:0]  active_count;
  logic [CNT_W-1:0]  active_count_next;
  logic [CNT_W-1:0]  count_inc;

  site_t             val_a;
  site_t             val_b;
  site_t             res_first;
  site_t             res_second;
  rule_t             res_rule;
  logic              res_shot;
  logic              write_a;
  logic              write_b;
  logic              left_half;
  logic [THR_W-1:0]  frac_ext;
  logic [THR_W-1:0]  thr_low;
  logic [THR_W-1:0]  thr_mid;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      rate_left_drift  <= THR_ZERO;
      rate_right_drift <= THR_ZERO;
      rate_annihilate  <= THR_FULL;
      rate_create      <= THR_ZERO;
      init_left_low    <= THR_ZERO;
      init_left_mid    <= THR_FULL;
      init_right_low   <= THR_ZERO;
      init_right_mid   <= THR_FULL;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_addr))
        REG_RATE_LEFT_DRIFT:  rate_left_drift  <= cfg_wdata;
        REG_RATE_RIGHT_DRIFT: rate_right_drift <= cfg_wdata;
        REG_RATE_ANNIHILATE:  rate_annihilate  <= cfg_wdata;
        REG_RATE_CREATE:      rate_create      <= cfg_wdata;
        REG_INIT_LEFT_LOW:    init_left_low    <= cfg_wdata;
        REG_INIT_LEFT_MID:    init_left_mid    <= cfg_wdata;
        REG_INIT_RIGHT_LOW:   init_right_low   <= cfg_wdata;
        REG_INIT_RIGHT_MID:   init_right_mid   <= cfg_wdata;
      endcase
    end
  end

  // Bank rows for the incoming item
  assign in_site_b   = in_site + SITE_W'(1);
  assign in_row_odd  = in_site[SITE_W-1:1];
  assign in_row_even = in_site[0] ? in_site_b[SITE_W-1:1] : in_site[SITE_W-1:1];

  // Capture the item
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func   <= func_t'(in_func);
      site_a <= in_site;
      frac   <= in_frac;
    end
  end

  // Bank rows for the captured item
  assign site_b   = site_a + SITE_W'(1);
  assign row_odd  = site_a[SITE_W-1:1];
  assign row_even = site_a[0] ? site_b[SITE_W-1:1] : site_a[SITE_W-1:1];

  // Lattice banks: read on capture, write on commit
  always_ff @(posedge clk) begin
    if (cmd.capture) rd_even <= even_bank[in_row_even];
    if (we_even)     even_bank[row_even] <= wd_even;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) rd_odd <= odd_bank[in_row_odd];
    if (we_odd)      odd_bank[row_odd] <= wd_odd;
  end

  assign val_a = site_a[0] ? rd_odd  : rd_even;
  assign val_b = site_a[0] ? rd_even : rd_odd;

  // Item evaluation
  assign count_inc = active_count + CNT_W'(1);
  assign frac_ext  = {1'b0, frac};
  assign left_half = !site_a[SITE_W-1];
  assign thr_low   = left_half ? init_left_low : init_right_low;
  assign thr_mid   = left_half ? init_left_mid : init_right_mid;

  always_comb begin
    res_first         = SITE_ZERO;
    res_second        = SITE_ZERO;
    res_rule          = RULE_NONE;
    res_shot          = 1'b0;
    write_a           = 1'b0;
    write_b           = 1'b0;
    active_count_next = active_count;
    case (func)
      FUNC_INIT: begin
        write_a = 1'b1;
        if (frac_ext < thr_low) begin
          res_first = SITE_NEG;
        end else if (frac_ext < thr_mid) begin
          res_first = SITE_ZERO;
        end else begin
          res_first = SITE_POS;
        end
      end
      FUNC_UPDATE: begin
        res_first  = val_a;
        res_second = val_b;
        if (val_a != SITE_NEG) begin
          write_a = 1'b1;
          write_b = 1'b1;
          // advance the active count, wrap at the shot interval
          if (count_inc == CNT_W'(SHOT_INTERVAL)) begin
            res_shot          = 1'b1;
            active_count_next = '0;
          end else begin
            active_count_next = count_inc;
          end
          if (val_a == SITE_ZERO && val_b == SITE_NEG && frac_ext < rate_left_drift) begin
            res_first  = SITE_NEG;
            res_second = SITE_ZERO;
            res_rule   = RULE_LEFT_DRIFT;
          end else if (val_a == SITE_POS && val_b == SITE_ZERO &&
                       frac_ext < rate_right_drift) begin
            res_first  = SITE_ZERO;
            res_second = SITE_POS;
            res_rule   = RULE_RIGHT_DRIFT;
          end else if (val_a == SITE_POS && val_b == SITE_NEG &&
                       frac_ext < rate_annihilate) begin
            res_first  = SITE_ZERO;
            res_second = SITE_ZERO;
            res_rule   = RULE_ANNIHILATE;
          end else if (val_a == SITE_ZERO && val_b == SITE_ZERO &&
                       frac_ext < rate_create) begin
            res_first  = SITE_NEG;
            res_second = SITE_POS;
            res_rule   = RULE_CREATE;
          end
        end
      end
      FUNC_READ: begin
        res_first = val_a;
      end
      default: begin
        res_first = SITE_ZERO;
      end
    endcase
  end

  // Route the write-back to the banks
  always_comb begin
    we_even = cmd.commit && (site_a[0] ? write_b : write_a);
    we_odd  = cmd.commit && (site_a[0] ? write_a : write_b);
    wd_even = site_a[0] ? res_second : res_first;
    wd_odd  = site_a[0] ? res_first  : res_second;
  end

  // Active update counter
  always_ff @(posedge clk) begin
    if (rst) begin
      active_count <= '0;
    end else if (cmd.commit) begin
      active_count <= active_count_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data <= {res_shot, res_rule, res_second, res_first};
    end
  end

  assign sts.out_stall = out_valid && !out_ready;

endmodule

>>> rtl/lattice_pair_jump_update_core.sv
// Channel   | Direction | Contents
// s_axis    | in        | tuser: func; tdata: site_index, random_fraction
// m_axis    | out       | tdata: first_value, second_value, rule_applied, shot_due
// cfg       | in        | write enable, register index, 17-bit value
//
// An item is accepted in idle, where both lattice banks are read; evaluation
// then computes the pair rule, writes the sites back and loads the result register.
// A stalled result register lets one more transaction in, which then waits in
// evaluation until the register frees; no further transaction is taken.
// Reset clears the controller, the active counter and the registers; the
// lattice itself has no reset, and a site is undefined until it is written.
module lattice_pair_jump_update_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [11:0] site_index, [27:12] random_fraction, [31:28] zero
  input  logic [lpju_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // [1:0] func
  input  logic [lpju_pkg::FUNC_W-1:0]        s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [1:0] first_value, [3:2] second_value, [6:4] rule_applied, [7] shot_due
  output logic [lpju_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  input  logic                               cfg_we,
  input  logic [lpju_pkg::REG_IDX_W-1:0]     cfg_addr,
  input  logic [lpju_pkg::THR_W-1:0]         cfg_wdata
);
  import lpju_pkg::*;

  lpju_cmd_t cmd;
  lpju_sts_t sts;

  lpju_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lpju_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_func   (s_axis_tuser),
    .in_site   (s_axis_tdata[SITE_W-1:0]),
    .in_frac   (s_axis_tdata[SITE_W +: FRAC_W]),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_data  (m_axis_tdata)
  );

  // One transaction at a time: no accept in the cycle after an accept
  assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while an item is in evaluation");

  // A fresh result appears only from the evaluation cycle
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result raised without an item in evaluation");

  // Every pair rule leaves the right neighbour at 0 or +1
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[6:4] != 3'(RULE_NONE)) |->
      (m_axis_tdata[3:2] == 2'(SITE_ZERO) || m_axis_tdata[3:2] == 2'(SITE_POS)))
    else $error("applied rule left the neighbour at -1");

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import lpju_pkg::*;

  // Code outside the defined operations: the block must answer with all zeros
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  typedef struct packed {
    site_t first;
    site_t second;
    rule_t rule;
    logic  shot;
  } site_result_t;

  typedef enum {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t        kind;
    logic [1:0]       f;
    logic [11:0]      site;
    logic [15:0]      frac;
    bit               typed;
    site_result_t     want;
    reg_idx_t         idx;
    logic [THR_W-1:0] val;
  } stim_row_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [IN_TDATA_W-1:0]   s_axis_tdata = '0;
  logic [FUNC_W-1:0]       s_axis_tuser = '0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0]  m_axis_tdata;
  logic                    cfg_we = 1'b0;
  logic [REG_IDX_W-1:0]    cfg_addr = '0;
  logic [THR_W-1:0]        cfg_wdata = '0;

  // Lattice mirror, written-site map, counter and thresholds
  site_t             sites [SITES];
  bit                site_set [SITES];
  logic [CNT_W-1:0]  active_updates = '0;
  logic [THR_W-1:0]  thr [8] = '{THR_ZERO, THR_ZERO, THR_FULL, THR_ZERO,
                                 THR_ZERO, THR_FULL, THR_ZERO, THR_FULL};

  site_result_t      result_q [$];
  stim_row_t         rows [$];
  bit                steady = 1'b0;
  int                fails = 0;
  int                items_in = 0;
  int                results_seen = 0;
  int                reg_writes = 0;
  int                shots_seen = 0;
  int                rule_seen [8];

  lattice_pair_jump_update_core uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Advance the lattice mirror by one item and return what the block should report
  function automatic site_result_t lattice_step(logic [1:0] f, logic [11:0] site,
                                                logic [15:0] frac);
    site_result_t     r;
    logic [11:0]      nb;
    logic [THR_W-1:0] lo;
    logic [THR_W-1:0] mid;
    site_t            a;
    site_t            b;
    r  = '{SITE_ZERO, SITE_ZERO, RULE_NONE, 1'b0};
    nb = site + 12'd1;
    case (f)
      FUNC_INIT: begin
        if (site < BANK_ROWS) begin
          lo  = thr[REG_INIT_LEFT_LOW];
          mid = thr[REG_INIT_LEFT_MID];
        end else begin
          lo  = thr[REG_INIT_RIGHT_LOW];
          mid = thr[REG_INIT_RIGHT_MID];
        end
        if (frac < lo) a = SITE_NEG;
        else if (frac < mid) a = SITE_ZERO;
        else a = SITE_POS;
        sites[site]    = a;
        site_set[site] = 1'b1;
        r.first        = a;
      end
      FUNC_UPDATE: begin
        a = sites[site];
        b = sites[nb];
        // A negative first site leaves everything untouched
        if (a != SITE_NEG) begin
          active_updates = active_updates + 1'b1;
          if (active_updates == SHOT_INTERVAL) begin
            r.shot         = 1'b1;
            active_updates = '0;
          end
          if (a == SITE_ZERO && b == SITE_NEG && frac < thr[REG_RATE_LEFT_DRIFT]) begin
            a = SITE_NEG; b = SITE_ZERO; r.rule = RULE_LEFT_DRIFT;
          end else if (a == SITE_POS && b == SITE_ZERO &&
                       frac < thr[REG_RATE_RIGHT_DRIFT]) begin
            a = SITE_ZERO; b = SITE_POS; r.rule = RULE_RIGHT_DRIFT;
          end else if (a == SITE_POS && b == SITE_NEG &&
                       frac < thr[REG_RATE_ANNIHILATE]) begin
            a = SITE_ZERO; b = SITE_ZERO; r.rule = RULE_ANNIHILATE;
          end else if (a == SITE_ZERO && b == SITE_ZERO && frac < thr[REG_RATE_CREATE]) begin
            a = SITE_NEG; b = SITE_POS; r.rule = RULE_CREATE;
          end
          sites[site] = a;
          sites[nb]   = b;
        end
        r.first  = a;
        r.second = b;
      end
      FUNC_READ: r.first = sites[site];
      default: ;
    endcase
    return r;
  endfunction

  function automatic stim_row_t item_row(logic [1:0] f, logic [11:0] site, logic [15:0] frac,
                                         bit typed, site_result_t want);
    stim_row_t row;
    row.kind  = ROW_ITEM;
    row.f     = f;
    row.site  = site;
    row.frac  = frac;
    row.typed = typed;
    row.want  = want;
    row.idx   = REG_RATE_LEFT_DRIFT;
    row.val   = '0;
    return row;
  endfunction

  function automatic stim_row_t cfg_row(reg_idx_t idx, logic [THR_W-1:0] val);
    stim_row_t row;
    row       = item_row(FUNC_INIT, '0, '0, 1'b0, '0);
    row.kind  = ROW_CFG;
    row.idx   = idx;
    row.val   = val;
    return row;
  endfunction

  // Offer one transaction, idling at random first, and log its expected result
  task automatic drive_item(logic [1:0] f, logic [11:0] site, logic [15:0] frac,
                            bit typed, site_result_t want);
    site_result_t p;
    while (!steady && $urandom_range(0, 99) < 36) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= f;
    s_axis_tdata  <= {4'b0, frac, site};
    do @(posedge clk); while (!s_axis_tready);
    p = lattice_step(f, site, frac);
    result_q.push_back(typed ? want : p);
    items_in++;
  endtask

  // Hold the input idle until every expected result has been taken
  task automatic drain_results();
    int waited;
    waited = 0;
    s_axis_tvalid <= 1'b0;
    while (result_q.size() != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    if (result_q.size() != 0) begin
      $error("%0d expected results never arrived", result_q.size());
      fails++;
      result_q.delete();
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [THR_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
    thr[idx] = val;
    reg_writes++;
  endtask

  // Take results with random back-pressure and compare against the oldest expectation
  always @(posedge clk) begin : result_check
    site_result_t want;
    site_result_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.first  = m_axis_tdata[1:0];
      got.second = m_axis_tdata[3:2];
      got.rule   = rule_t'(m_axis_tdata[6:4]);
      got.shot   = m_axis_tdata[7];
      results_seen++;
      if (result_q.size() == 0) begin
        $error("result transaction with nothing expected, tdata %h", m_axis_tdata);
        fails++;
      end else begin
        want = result_q.pop_front();
        if (got.first !== want.first) begin
          $error("first_value: expected %0d, got %0d", want.first, got.first);
          fails++;
        end
        if (got.second !== want.second) begin
          $error("second_value: expected %0d, got %0d", want.second, got.second);
          fails++;
        end
        if (got.rule !== want.rule) begin
          $error("rule_applied: expected %0d, got %0d", want.rule, got.rule);
          fails++;
        end
        if (got.shot !== want.shot) begin
          $error("shot_due: expected %0d, got %0d", want.shot, got.shot);
          fails++;
        end
        rule_seen[got.rule]++;
        if (got.shot === 1'b1) shots_seen++;
      end
    end
    m_axis_tready <= steady || ($urandom_range(0, 99) >= 36);
  end

  initial begin
    int               ph;
    int               n;
    int               k;
    int               sel;
    logic [1:0]       f;
    logic [11:0]      s;
    logic [11:0]      base;
    logic [15:0]      r;
    logic [THR_W-1:0] v;

    // Directed rows: reset thresholds first
    rows.push_back(item_row(FUNC_INIT, 12'd0, 16'd0, 1'b1,
                            '{SITE_ZERO, SITE_ZERO, RULE_NONE, 1'b0}));
    rows.push_back(item_row(FUNC_INIT, 12'd1, 16'hFFFF, 1'b1,
                            '{SITE_ZERO, SITE_ZERO, RULE_NONE, 1'b0}));
    rows.push_back(item_row(FUNC_READ, 12'd0, 16'd0, 1'b1,
                            '{SITE_ZERO, SITE_ZERO, RULE_NONE, 1'b0}));
    rows.push_back(item_row(FUNC_UPDATE, 12'd0, 16'd0, 1'b1,
                            '{SITE_ZERO, SITE_ZERO, RULE_NONE, 1'b0}));
    rows.push_back(item_row(FUNC_UNUSED, 12'hFFF, 16'hFFFF, 1'b1,
                            '{SITE_ZERO, SITE_ZERO, RULE_NONE, 1'b0}));
    // Split init thresholds, then both halves and the wrap at the top of the ring
    rows.push_back(cfg_row(REG_INIT_LEFT_LOW, 17'd32768));
    rows.push_back(cfg_row(REG_INIT_LEFT_MID, 17'd49152));
    rows.push_back(cfg_row(REG_INIT_RIGHT_LOW, 17'd16384));
    rows.push_back(cfg_row(REG_INIT_RIGHT_MID, 17'd32768));
    rows.push_back(item_row(FUNC_INIT, 12'd2047, 16'd32767, 1'b1,
                            '{SITE_NEG, SITE_ZERO, RULE_NONE, 1'b0}));
    rows.push_back(item_row(FUNC_INIT, 12'd2048, 16'd32768, 1'b1,
                            '{SITE_POS, SITE_ZERO, RULE_NONE, 1'b0}));
    rows.push_back(item_row(FUNC_INIT, 12'hFFF, 16'd16383, 1'b1,
                            '{SITE_NEG, SITE_ZERO, RULE_NONE, 1'b0}));
    rows.push_back(item_row(FUNC_INIT, 12'd0, 16'd0, 1'b1,
                            '{SITE_NEG, SITE_ZERO, RULE_NONE, 1'b0}));
    rows.push_back(item_row(FUNC_INIT, 12'd1, 16'hFFFF, 1'b1,
                            '{SITE_POS, SITE_ZERO, RULE_NONE, 1'b0}));
    rows.push_back(item_row(FUNC_READ, 12'hFFF, 16'd0, 1'b1,
                            '{SITE_NEG, SITE_ZERO, RULE_NONE, 1'b0}));
    // Negative first site: no count, no rule, neighbour still reported
    rows.push_back(item_row(FUNC_UPDATE, 12'hFFF, 16'd0, 1'b1,
                            '{SITE_NEG, SITE_NEG, RULE_NONE, 1'b0}));
    // Open every rule fully and set up one pair for each
    rows.push_back(cfg_row(REG_RATE_LEFT_DRIFT, THR_FULL));
    rows.push_back(cfg_row(REG_RATE_RIGHT_DRIFT, THR_FULL));
    rows.push_back(cfg_row(REG_RATE_ANNIHILATE, THR_FULL));
    rows.push_back(cfg_row(REG_RATE_CREATE, THR_FULL));
    rows.push_back(item_row(FUNC_INIT, 12'd8, 16'd40000, 1'b1,
                            '{SITE_ZERO, SITE_ZERO, RULE_NONE, 1'b0}));
    rows.push_back(item_row(FUNC_INIT, 12'd9, 16'd0, 1'b1,
                            '{SITE_NEG, SITE_ZERO, RULE_NONE, 1'b0}));
    rows.push_back(item_row(FUNC_INIT, 12'd10, 16'hFFFF, 1'b1,
                            '{SITE_POS, SITE_ZERO, RULE_NONE, 1'b0}));
    rows.push_back(item_row(FUNC_INIT, 12'd11, 16'd40000, 1'b1,
                            '{SITE_ZERO, SITE_ZERO, RULE_NONE, 1'b0}));
    rows.push_back(item_row(FUNC_INIT, 12'd12, 16'hFFFF, 1'b1,
                            '{SITE_POS, SITE_ZERO, RULE_NONE, 1'b0}));
    rows.push_back(item_row(FUNC_INIT, 12'd13, 16'd0, 1'b1,
                            '{SITE_NEG, SITE_ZERO, RULE_NONE, 1'b0}));
    rows.push_back(item_row(FUNC_INIT, 12'd14, 16'd40000, 1'b1,
                            '{SITE_ZERO, SITE_ZERO, RULE_NONE, 1'b0}));
    rows.push_back(item_row(FUNC_INIT, 12'd15, 16'd40000, 1'b1,
                            '{SITE_ZERO, SITE_ZERO, RULE_NONE, 1'b0}));
    rows.push_back(item_row(FUNC_UPDATE, 12'd8, 16'hFFFF, 1'b0, '0));
    rows.push_back(item_row(FUNC_UPDATE, 12'd10, 16'hFFFF, 1'b0, '0));
    rows.push_back(item_row(FUNC_UPDATE, 12'd12, 16'hFFFF, 1'b0, '0));
    rows.push_back(item_row(FUNC_UPDATE, 12'd14, 16'hFFFF, 1'b0, '0));

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Walk the directed table
    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) begin
        drain_results();
        write_reg(rows[i].idx, rows[i].val);
      end else begin
        drive_item(rows[i].f, rows[i].site, rows[i].frac, rows[i].typed, rows[i].want);
      end
    end

    // Random phases, each under its own set of thresholds
    for (ph = 0; ph < 8; ph++) begin
      drain_results();
      for (k = 0; k < 8; k++) begin
        case (ph)
          0:       v = THR_ZERO;
          1:       v = THR_FULL;
          2:       v = k[0] ? 17'd1 : 17'd65535;
          default: v = 17'($urandom_range(0, 65536));
        endcase
        write_reg(reg_idx_t'(k), v);
      end
      case (ph)
        0:       base = 12'd4088;
        1:       base = 12'd2040;
        default: base = 12'($urandom);
      endcase
      steady = (ph == 3);
      for (n = 0; n < 100; n++) begin
        s = ($urandom_range(0, 99) < 90) ? base + 12'($urandom_range(0, 15))
                                          : 12'($urandom);
        sel = $urandom_range(0, 99);
        if (sel < 45) f = FUNC_UPDATE;
        else if (sel < 70) f = FUNC_INIT;
        else if (sel < 95) f = FUNC_READ;
        else f = FUNC_UNUSED;
        // Never touch a site that has not been written: write it instead
        if (f == FUNC_UPDATE && !(site_set[s] && site_set[s + 12'd1])) begin
          if (site_set[s]) s = s + 12'd1;
          f = FUNC_INIT;
        end else if (f == FUNC_READ && !site_set[s]) begin
          f = FUNC_INIT;
        end
        // Mostly uniform fractions, some right on a threshold edge
        r = 16'($urandom);
        if ($urandom_range(0, 99) < 15) begin
          v = thr[$urandom_range(0, 7)];
          r = (v >= THR_FULL) ? 16'hFFFF : v[15:0];
          if ($urandom_range(0, 1) && r != 16'd0) r = r - 16'd1;
        end
        drive_item(f, s, r, 1'b0, '0);
      end
    end
    steady = 1'b0;

    drain_results();
    $display("Covered %0d input transactions, %0d results and %0d register writes.",
             items_in, results_seen, reg_writes);
    $display("Rules seen: none %0d, left %0d, right %0d, annihilate %0d, create %0d; shots %0d.",
             rule_seen[RULE_NONE], rule_seen[RULE_LEFT_DRIFT], rule_seen[RULE_RIGHT_DRIFT],
             rule_seen[RULE_ANNIHILATE], rule_seen[RULE_CREATE], shots_seen);
    if (fails == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run
  initial begin
    #(5_000_000);
    $display("tb: FAIL");
    $finish;
  end

endmodule

>>> lattice_pair_jump_update_core.f
rtl/lpju_pkg.sv
rtl/lpju_ctrl.sv
rtl/lpju_datapath.sv
rtl/lattice_pair_jump_update_core.sv
tb/tb.sv
